### hw/rtl/dmst_pkg.sv
// Shared types and constants for the dense Prim spanning tree block.
// No dependencies; used by dmst_ctrl, dmst_dp and dense_prim_mst.
package dmst_pkg;

    // Fixed field widths
    localparam int NODE_BITS  = 8;
    localparam int EDGE_BITS  = 16;
    localparam int TOTAL_BITS = 23;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    // Input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_NODE_COUNT = 1'b0;   // word index, paddr[2]

    // Controller to datapath commands
    typedef struct packed {
        logic run_start;
        logic load_wr;
        logic clr_wr;
        logic init_rd;
        logic scan_rd;
        logic relax_rd;
        logic mark;
        logic out_load;
        logic out_conn;
    } dmst_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic found;
    } dmst_sts_t;

endpackage

### hw/rtl/dmst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dmst_ctrl.sv
// Sequencer for the spanning tree block: matrix clear, edge loads, Prim steps.
// Depends on dmst_pkg; drives dmst_dp through dmst_ctl_t.
module dmst_ctrl #(
    parameter int MAX_NODES = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic [$clog2(MAX_NODES)-1:0]  last_node,
    input  dmst_pkg::dmst_sts_t           sts,
    output dmst_pkg::dmst_ctl_t           ctl,
    output logic [$clog2(MAX_NODES)-1:0]  idx,
    output logic [2*$clog2(MAX_NODES)-1:0] clr_addr
);

    localparam int NB = $clog2(MAX_NODES);
    localparam int AW = 2 * NB;

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_INIT      = 8'b0000_0100,
        S_SCAN      = 8'b0000_1000,
        S_SCAN_WAIT = 8'b0001_0000,
        S_MARK      = 8'b0010_0000,
        S_RELAX     = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } dmst_state_t;

    dmst_state_t   state_reg, state_next;
    logic [NB-1:0] idx_reg, idx_next;
    logic [NB-1:0] step_reg, step_next;
    logic [NB-1:0] step_inc;
    logic [AW-1:0] clr_reg, clr_next;
    logic          conn_reg, conn_next;
    logic          out_valid_reg, out_valid_next;

    assign step_inc = step_reg + 1'b1;

    // Next-state and command decode
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        clr_next   = clr_reg;
        conn_next  = conn_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cmd == dmst_pkg::CMD_RUN)
                    begin
                        ctl.run_start = 1'b1;
                        idx_next      = '0;
                        step_next     = '0;
                        state_next    = S_INIT;
                    end
                    else
                    begin
                        ctl.load_wr = 1'b1;
                    end
                end
            end
            S_INIT:
            begin
                ctl.init_rd = 1'b1;
                if (idx_reg == last_node)
                begin
                    idx_next = '0;
                    if (last_node == '0)
                    begin
                        // single node: nothing to pick
                        conn_next  = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                ctl.scan_rd = 1'b1;
                if (idx_reg == last_node)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN_WAIT:
            begin
                // last key compare lands this cycle
                if (sts.found)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    conn_next  = 1'b0;
                    state_next = S_FINISH;
                end
            end
            S_MARK:
            begin
                ctl.mark  = 1'b1;
                step_next = step_inc;
                idx_next  = '0;
                if (step_inc == last_node)
                begin
                    conn_next  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RELAX;
                end
            end
            S_RELAX:
            begin
                ctl.relax_rd = 1'b1;
                if (idx_reg == last_node)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_conn = conn_reg;
                    state_next   = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // Output beat tracking
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers; reset starts with a full matrix clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            step_reg      <= '0;
            clr_reg       <= '0;
            conn_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            conn_reg      <= conn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign idx       = idx_reg;
    assign clr_addr  = clr_reg;

    // A finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded while previous beat pending");

    // A result only appears out of the finish state
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");

endmodule

### hw/rtl/dmst_dp.sv
// Datapath: cost matrix and key memories, min-key search, relaxation, total.
// Depends on dmst_pkg and dmst_ram; commanded by dmst_ctrl.
module dmst_dp #(
    parameter int MAX_NODES = 128,
    parameter int COST_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dmst_pkg::dmst_ctl_t                    ctl,
    input  logic [$clog2(MAX_NODES)-1:0]           idx,
    input  logic [2*$clog2(MAX_NODES)-1:0]         clr_addr,
    input  logic [dmst_pkg::NODE_BITS-1:0]         node_a,
    input  logic [dmst_pkg::NODE_BITS-1:0]         node_b,
    input  logic [dmst_pkg::EDGE_BITS-1:0]         edge_cost,
    output dmst_pkg::dmst_sts_t                    sts,
    output logic [dmst_pkg::TOTAL_BITS-1:0]        total_cost,
    output logic                                   connected
);

    localparam int NB    = $clog2(MAX_NODES);
    localparam int AW    = 2 * NB;
    localparam int KW    = COST_BITS;
    localparam int CW    = (NB + 1 > dmst_pkg::NODE_BITS) ? NB + 1 : dmst_pkg::NODE_BITS;
    localparam int TB    = dmst_pkg::TOTAL_BITS;
    localparam int SUM_W = ((COST_BITS > TB) ? COST_BITS : TB) + 1;

    // Memory ports
    logic          mat_we;
    logic [AW-1:0] mat_waddr, mat_raddr;
    logic [KW-1:0] mat_wdata, mat_rdata;
    logic          key_we;
    logic [NB-1:0] key_waddr;
    logic [KW:0]   key_wdata, key_rdata;

    // Read pipeline tags (data arrives in the cycle after issue)
    logic          init_d_reg, scan_d_reg, relax_d_reg;
    logic [NB-1:0] idx_d_reg;

    // Search and accumulation state
    logic          found_reg, found_next;
    logic [NB-1:0] pick_reg, pick_next;
    logic [KW-1:0] key_reg, key_next;
    logic [TB-1:0] total_reg, total_next;
    logic [TB-1:0] total_cost_reg;
    logic          connected_reg;

    // Load decode
    logic [CW-1:0] a_ext, b_ext, a_m1, b_m1;
    logic          load_ok;
    logic [NB-1:0] a_idx, b_idx, ld_lo, ld_hi;
    logic [NB-1:0] rx_lo, rx_hi;
    logic [KW-1:0] cost_m;

    // Key memory fields at the returned index
    logic          rd_in_tree;
    logic [KW-1:0] rd_key;
    logic          found_eff;
    logic          scan_take;
    logic          relax_take;
    logic [SUM_W-1:0] sum;

    assign a_ext   = CW'(node_a);
    assign b_ext   = CW'(node_b);
    assign a_m1    = a_ext - 1'b1;
    assign b_m1    = b_ext - 1'b1;
    assign a_idx   = NB'(a_m1);
    assign b_idx   = NB'(b_m1);
    assign load_ok = (a_ext != '0) && (b_ext != '0)
                  && (a_ext <= CW'(MAX_NODES)) && (b_ext <= CW'(MAX_NODES));
    assign ld_lo   = (a_idx < b_idx) ? a_idx : b_idx;
    assign ld_hi   = (a_idx < b_idx) ? b_idx : a_idx;
    assign cost_m  = KW'(edge_cost);

    // Only the upper triangle is stored: pair (lo, hi)
    assign rx_lo = (pick_reg < idx) ? pick_reg : idx;
    assign rx_hi = (pick_reg < idx) ? idx : pick_reg;

    // Cost matrix ports
    always_comb
    begin
        if (ctl.clr_wr)
        begin
            mat_waddr = clr_addr;
            mat_wdata = '0;
        end
        else
        begin
            mat_waddr = {ld_lo, ld_hi};
            mat_wdata = cost_m;
        end
        mat_we = ctl.clr_wr || (ctl.load_wr && load_ok);
        if (ctl.init_rd)
        begin
            mat_raddr = {{NB{1'b0}}, idx};
        end
        else
        begin
            mat_raddr = {rx_lo, rx_hi};
        end
    end

    dmst_ram #(
        .WIDTH (KW),
        .DEPTH (1 << AW)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    assign rd_in_tree = key_rdata[KW];
    assign rd_key     = key_rdata[KW-1:0];

    // Relax: a shorter edge into an out-of-tree node lowers its key
    assign relax_take = relax_d_reg && !rd_in_tree && (mat_rdata != '0)
                     && ((rd_key == '0) || (mat_rdata < rd_key));

    // Key memory write sources; {in_tree, key}
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = idx_d_reg;
        key_wdata = {1'b0, mat_rdata};
        priority if (ctl.mark)
        begin
            key_we    = 1'b1;
            key_waddr = pick_reg;
            key_wdata = {1'b1, key_reg};
        end
        else if (init_d_reg)
        begin
            key_we    = 1'b1;
            key_wdata = {(idx_d_reg == '0), mat_rdata};
        end
        else if (relax_take)
        begin
            key_we = 1'b1;
        end
        else
        begin
            key_we = 1'b0;
        end
    end

    dmst_ram #(
        .WIDTH (KW + 1),
        .DEPTH (MAX_NODES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (idx),
        .rdata (key_rdata)
    );

    // Min-key search; <= lets the highest index win ties
    assign found_eff = (idx_d_reg == '0) ? 1'b0 : found_reg;
    assign scan_take = scan_d_reg && !rd_in_tree && (rd_key != '0)
                    && (!found_eff || (rd_key <= key_reg));

    always_comb
    begin
        found_next = found_reg;
        pick_next  = pick_reg;
        key_next   = key_reg;
        if (scan_take)
        begin
            found_next = 1'b1;
            pick_next  = idx_d_reg;
            key_next   = rd_key;
        end
        else if (scan_d_reg && (idx_d_reg == '0))
        begin
            found_next = 1'b0;
        end
    end

    // Saturating total
    assign sum = SUM_W'(total_reg) + SUM_W'(key_reg);

    always_comb
    begin
        total_next = total_reg;
        if (ctl.run_start)
        begin
            total_next = '0;
        end
        else if (ctl.mark)
        begin
            total_next = (sum > SUM_W'(dmst_pkg::TOTAL_MAX)) ? dmst_pkg::TOTAL_MAX : TB'(sum);
        end
    end

    // Read pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_d_reg  <= 1'b0;
            scan_d_reg  <= 1'b0;
            relax_d_reg <= 1'b0;
        end
        else
        begin
            init_d_reg  <= ctl.init_rd;
            scan_d_reg  <= ctl.scan_rd;
            relax_d_reg <= ctl.relax_rd;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_d_reg <= idx;
        found_reg <= found_next;
        pick_reg  <= pick_next;
        key_reg   <= key_next;
        total_reg <= total_next;
        if (ctl.out_load)
        begin
            total_cost_reg <= ctl.out_conn ? total_reg : '0;
            connected_reg  <= ctl.out_conn;
        end
    end

    // Search status includes the compare landing this cycle
    assign sts.found  = found_next;
    assign total_cost = total_cost_reg;
    assign connected  = connected_reg;

    // Read results of different phases never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({init_d_reg, scan_d_reg, relax_d_reg, ctl.mark}))
        else $error("overlapping key memory phases");

    // A node is only marked after a search found one
    a_mark_found: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mark |-> found_reg)
        else $error("mark without a found node");

endmodule

### hw/rtl/dense_prim_mst.sv
// Top level of the dense Prim minimum spanning tree block.
// Depends on dmst_pkg, dmst_ctrl, dmst_dp (which holds two dmst_ram).
//
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+-----------------------------
//  input    | in_valid/in_ready cmd node_a node_b       | edge load or run command
//           | edge_cost                                 |
//  output   | out_valid/out_ready total_cost connected  | one per run command
//  config   | psel penable pwrite paddr pwdata prdata   | node_count at address 0
//           | pready                                    |
//
// Edge loads: one beat per cycle while idle, a single matrix write each for
//   node numbers 1..MAX_NODES. Run: key init over the n nodes, then per step
//   a scan of the n keys, a wait for the last compare, one mark and, in every
//   step but the last, a relax pass over the n nodes.
// After each run and after reset the cost matrix is cleared one entry a cycle,
//   all 4**ceil(log2(MAX_NODES)) entries (16384 by default); no beat is taken then.
// A load beat is taken while a result waits; a finished run holds until the
//   output register is free.
module dense_prim_mst #(
    parameter int MAX_NODES = 128,
    parameter int COST_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic [dmst_pkg::NODE_BITS-1:0]       node_a,
    input  logic [dmst_pkg::NODE_BITS-1:0]       node_b,
    input  logic [dmst_pkg::EDGE_BITS-1:0]       edge_cost,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [dmst_pkg::TOTAL_BITS-1:0]      total_cost,
    output logic                                 connected,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dmst_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [dmst_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [dmst_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int NB = $clog2(MAX_NODES);
    localparam int AW = 2 * NB;
    localparam int CW = (NB + 1 > dmst_pkg::NODE_BITS) ? NB + 1 : dmst_pkg::NODE_BITS;

    logic [dmst_pkg::NODE_BITS-1:0] node_count_reg, node_count_next;
    logic                           reg_sel;
    logic [CW-1:0]                  cnt_ext;
    logic [NB-1:0]                  last_node;
    dmst_pkg::dmst_ctl_t            ctl;
    dmst_pkg::dmst_sts_t            sts;
    logic [NB-1:0]                  idx;
    logic [AW-1:0]                  clr_addr;

    // Register file
    assign reg_sel = (paddr[2] == dmst_pkg::REG_NODE_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? dmst_pkg::APB_DATA_BITS'(node_count_reg) : '0;

    always_comb
    begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            node_count_next = pwdata[dmst_pkg::NODE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= dmst_pkg::NODE_BITS'(1);
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    // Highest active node index: 0 acts as 1, clamp to MAX_NODES
    assign cnt_ext = CW'(node_count_reg);

    always_comb
    begin
        priority if (cnt_ext == '0)
        begin
            last_node = '0;
        end
        else if (cnt_ext > CW'(MAX_NODES))
        begin
            last_node = NB'(MAX_NODES - 1);
        end
        else
        begin
            last_node = NB'(cnt_ext - 1'b1);
        end
    end

    dmst_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .last_node (last_node),
        .sts       (sts),
        .ctl       (ctl),
        .idx       (idx),
        .clr_addr  (clr_addr)
    );

    dmst_dp #(
        .MAX_NODES (MAX_NODES),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .idx        (idx),
        .clr_addr   (clr_addr),
        .node_a     (node_a),
        .node_b     (node_b),
        .edge_cost  (edge_cost),
        .sts        (sts),
        .total_cost (total_cost),
        .connected  (connected)
    );

endmodule
